// ===== hdl/srop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srop_pkg
// Shared constants, register indexes and types for the scan range to
// obstacle points block.
// ----------------------------------------------------------------------------
package srop_pkg;

  // parameter defaults
  localparam int unsigned DEF_ANGLE_BITS       = 16;
  localparam int unsigned DEF_RANGE_BITS       = 16;
  localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;

  // fixed field widths
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STRIDE_W   = 11;
  localparam int unsigned COUNT_W    = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_STRIDE = 2'd3;

  // per beam decision handed from the beam control to the pipeline
  typedef struct packed {
    logic kept;
    logic last;
    logic sin_neg;
    logic cos_neg;
  } beam_flags_t;

endpackage

// ===== hdl/srop_beam_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srop_beam_ctrl
// Configuration registers, stride countdown and running beam angle. Decides
// per beam whether it is kept and forms the sine and cosine table indexes.
// ----------------------------------------------------------------------------
module srop_beam_ctrl #(
  parameter int unsigned ANGLE_BITS       = srop_pkg::DEF_ANGLE_BITS,
  parameter int unsigned RANGE_BITS       = srop_pkg::DEF_RANGE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = srop_pkg::DEF_SINE_TABLE_DEPTH,
  localparam int unsigned IdxW            = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srop_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srop_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                accept_i,
  input  logic [srop_pkg::RANGE_W-1:0]        range_mm_i,
  input  logic                                scan_last_i,
  output srop_pkg::beam_flags_t               flags_o,
  output logic [srop_pkg::RANGE_W-1:0]        range_o,
  output logic [IdxW-1:0]                     sin_idx_o,
  output logic [IdxW-1:0]                     cos_idx_o
);
  import srop_pkg::*;

  localparam int unsigned AngleW   = ANGLE_BITS;
  localparam int unsigned IdxProdW = AngleW - 2 + IdxW + 1;
  localparam logic [IdxProdW-1:0] DepthP  = IdxProdW'(SINE_TABLE_DEPTH);
  localparam logic [IdxProdW-1:0] IdxRnd  = IdxProdW'(1) << (AngleW - 3);
  localparam logic [IdxW:0]       DepthI  = (IdxW + 1)'(SINE_TABLE_DEPTH);
  localparam logic [AngleW-1:0]   Quarter = AngleW'(1) << (AngleW - 2);
  localparam logic [AngleW-1:0]   Band3   = AngleW'(3) << (AngleW - 5);
  localparam logic [AngleW-1:0]   Band5   = AngleW'(5) << (AngleW - 5);
  localparam logic [AngleW-1:0]   Band11  = AngleW'(11) << (AngleW - 5);
  localparam int unsigned RangeMaxInt =
    (RANGE_BITS >= RANGE_W) ? ((1 << RANGE_W) - 1) : ((1 << RANGE_BITS) - 1);
  localparam logic [RANGE_W-1:0]  RangeMax = RANGE_W'(RangeMaxInt);
  localparam logic [STRIDE_W-1:0] StrideMax = STRIDE_W'(1024);

  logic signed [CFG_DATA_W-1:0] start_angle_q, start_angle_d;
  logic signed [CFG_DATA_W-1:0] angle_step_q, angle_step_d;
  logic [RANGE_W-1:0]           min_range_q, min_range_d;
  logic [STRIDE_W-1:0]          beam_stride_q, beam_stride_d;
  logic [COUNT_W-1:0]           countdown_q, countdown_d;
  logic [AngleW-1:0]            beam_angle_q, beam_angle_d;

  logic [STRIDE_W-1:0] stride_eff;
  logic                use_beam;
  logic [COUNT_W-1:0]  countdown_step;
  logic [AngleW-1:0]   start_ext;
  logic [AngleW-1:0]   step_ext;
  logic [AngleW-1:0]   angle_mag;
  logic                in_band;
  logic [RANGE_W-1:0]  range_sat;
  logic [AngleW-1:0]   cos_angle;

  // quarter wave table index for one angle
  function automatic logic [IdxW:0] table_index(input logic [AngleW-1:0] u);
    logic [IdxProdW-1:0] prod;
    logic [IdxW:0]       idx;
    prod = IdxProdW'(u[AngleW-3:0]) * DepthP + IdxRnd;
    idx  = prod[IdxProdW-1:AngleW-2];
    if (idx > DepthI) begin
      idx = DepthI;
    end
    if (u[AngleW-2]) begin
      idx = DepthI - idx;
    end
    return idx;
  endfunction

  // stride clamp and countdown step
  always_comb begin
    if (beam_stride_q == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (beam_stride_q > StrideMax) begin
      stride_eff = StrideMax;
    end else begin
      stride_eff = beam_stride_q;
    end
    use_beam       = (countdown_q == '0);
    countdown_step = use_beam ? COUNT_W'(stride_eff - STRIDE_W'(1))
                              : countdown_q - COUNT_W'(1);
  end

  // angle registers taken to angle width
  assign start_ext = AngleW'(start_angle_q);
  assign step_ext  = AngleW'(angle_step_q);

  // pillar band test on the absolute angle
  always_comb begin
    angle_mag = beam_angle_q[AngleW-1] ? (AngleW'(0) - beam_angle_q) : beam_angle_q;
    in_band   = ((angle_mag > Band3) && (angle_mag < Band5)) || (angle_mag > Band11);
  end

  // range saturation and keep decision
  assign range_sat = (range_mm_i > RangeMax) ? RangeMax : range_mm_i;
  assign cos_angle = beam_angle_q + Quarter;

  always_comb begin
    flags_o.kept    = use_beam && (range_sat > min_range_q) && !in_band;
    flags_o.last    = scan_last_i;
    flags_o.sin_neg = beam_angle_q[AngleW-1];
    flags_o.cos_neg = cos_angle[AngleW-1];
    range_o         = range_sat;
    sin_idx_o       = IdxW'(table_index(beam_angle_q));
    cos_idx_o       = IdxW'(table_index(cos_angle));
  end

  // next state: writes to start angle, angle step or stride restart the scan, beams advance it
  always_comb begin
    start_angle_d = start_angle_q;
    angle_step_d  = angle_step_q;
    min_range_d   = min_range_q;
    beam_stride_d = beam_stride_q;
    countdown_d   = countdown_q;
    beam_angle_d  = beam_angle_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_ANGLE: begin
          start_angle_d = cfg_wdata_i;
          countdown_d   = '0;
          beam_angle_d  = AngleW'(signed'(cfg_wdata_i));
        end
        REG_ANGLE_STEP: begin
          angle_step_d = cfg_wdata_i;
          countdown_d  = '0;
          beam_angle_d = start_ext;
        end
        REG_MIN_RANGE: begin
          min_range_d = cfg_wdata_i;
        end
        REG_BEAM_STRIDE: begin
          beam_stride_d = cfg_wdata_i[STRIDE_W-1:0];
          countdown_d   = '0;
          beam_angle_d  = start_ext;
        end
        default: begin
          min_range_d = min_range_q;
        end
      endcase
    end else if (accept_i) begin
      if (scan_last_i) begin
        countdown_d  = '0;
        beam_angle_d = start_ext;
      end else begin
        countdown_d  = countdown_step;
        beam_angle_d = beam_angle_q + step_ext;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= 16'sh8000;
      angle_step_q  <= 16'sd91;
      min_range_q   <= '0;
      beam_stride_q <= STRIDE_W'(1);
      countdown_q   <= '0;
      beam_angle_q  <= AngleW'(16'sh8000);
    end else begin
      start_angle_q <= start_angle_d;
      angle_step_q  <= angle_step_d;
      min_range_q   <= min_range_d;
      beam_stride_q <= beam_stride_d;
      countdown_q   <= countdown_d;
      beam_angle_q  <= beam_angle_d;
    end
  end

endmodule

// ===== hdl/srop_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srop_sine_rom
// Quarter wave sine table in Q15 with two registered read ports, one for
// sine and one for cosine. Contents are built at elaboration.
// ----------------------------------------------------------------------------
module srop_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = srop_pkg::DEF_SINE_TABLE_DEPTH,
  localparam int unsigned IdxW            = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [IdxW-1:0]               sin_idx_i,
  input  logic [IdxW-1:0]               cos_idx_i,
  output logic [srop_pkg::MAG_W-1:0]    sin_mag_o,
  output logic [srop_pkg::MAG_W-1:0]    cos_mag_o
);
  import srop_pkg::*;

  localparam int unsigned TableLen = SINE_TABLE_DEPTH + 1;
  localparam int unsigned SineDepth = SINE_TABLE_DEPTH;

  typedef logic [MAG_W-1:0] rom_t [TableLen];

  // polynomial sine over a quarter wave, phase in Q30
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    for (int k = 0; k < TableLen; k++) begin
      x  = (64'(k) * 64'd1686629713) / 64'(SineDepth);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      e  = (s + 64'd16384) >> 15;
      if (e > 64'd32768) begin
        e = 64'd32768;
      end
      tbl[k] = MAG_W'(e);
    end
    return tbl;
  endfunction

  localparam rom_t SineRom = build_rom();

  // registered reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_o <= SineRom[sin_idx_i];
      cos_mag_o <= SineRom[cos_idx_i];
    end
  end

endmodule

// ===== hdl/srop_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srop_scale
// One coordinate: range times Q15 sine magnitude, rounded half away from
// zero, saturated and signed. Zero when the beam was not kept.
// ----------------------------------------------------------------------------
module srop_scale (
  input  logic [srop_pkg::RANGE_W-1:0]       range_i,
  input  logic [srop_pkg::MAG_W-1:0]         mag_i,
  input  logic                               neg_i,
  input  logic                               kept_i,
  output logic signed [srop_pkg::COORD_W-1:0] coord_o
);
  import srop_pkg::*;

  localparam int unsigned ProdW = RANGE_W + MAG_W;

  logic [ProdW-1:0]   prod;
  logic [ProdW:0]     rounded;
  logic [ProdW-15:0]  scaled;
  logic [RANGE_W-1:0] sat;

  // multiply, round, saturate, apply sign
  always_comb begin
    prod    = ProdW'(range_i) * ProdW'(mag_i);
    rounded = (ProdW + 1)'(prod) + (ProdW + 1)'(16384);
    scaled  = rounded[ProdW:15];
    sat     = (scaled > (ProdW - 14)'(65535)) ? RANGE_W'(65535) : scaled[RANGE_W-1:0];
    if (!kept_i) begin
      coord_o = '0;
    end else if (neg_i) begin
      coord_o = COORD_W'(0) - COORD_W'(sat);
    end else begin
      coord_o = COORD_W'(sat);
    end
  end

endmodule

// ===== hdl/scan_range_to_obstacle_points.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_range_to_obstacle_points
// Laser scan filter: strides beams, drops short ranges and pillar bands and
// turns kept beams into x/y obstacle points.
// ----------------------------------------------------------------------------
// Takes one range word per beam and can accept a word in every cycle while the
// output is not held back. A beam first has sine and cosine looked up in the
// registered quarter wave table, then the two range multiplies are done into
// the output register. Beams that are neither kept nor the last of a scan give
// no result word. Output back pressure stalls the pipeline; input ready stays
// high while the table stage is empty or moving. Configuration writes to start
// angle, angle step or beam stride restart the scan counters and are meant for
// times when no beam is in flight.
module scan_range_to_obstacle_points #(
  parameter int unsigned ANGLE_BITS       = srop_pkg::DEF_ANGLE_BITS,
  parameter int unsigned RANGE_BITS       = srop_pkg::DEF_RANGE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = srop_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srop_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [srop_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [srop_pkg::RANGE_W-1:0]         range_mm_i,
  input  logic                                 scan_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [srop_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [srop_pkg::COORD_W-1:0]  point_y_o,
  output logic                                 point_valid_o,
  output logic                                 scan_end_o
);
  import srop_pkg::*;

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH + 1);

  beam_flags_t         beam_flags;
  logic [RANGE_W-1:0]  beam_range;
  logic [IdxW-1:0]     sin_idx;
  logic [IdxW-1:0]     cos_idx;
  logic                accept;
  logic                lut_adv;

  logic                lut_valid_q;
  beam_flags_t         lut_flags_q;
  logic [RANGE_W-1:0]  lut_range_q;
  logic [MAG_W-1:0]    sin_mag;
  logic [MAG_W-1:0]    cos_mag;

  logic signed [COORD_W-1:0] x_d;
  logic signed [COORD_W-1:0] y_d;
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic                      kept_q;
  logic                      end_q;

  // handshake: table stage moves when the output register is free or taken
  assign lut_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !lut_valid_q || lut_adv;
  assign accept     = in_valid_i && in_ready_o;

  // beam control and configuration
  srop_beam_ctrl #(
    .ANGLE_BITS       (ANGLE_BITS),
    .RANGE_BITS       (RANGE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .range_mm_i  (range_mm_i),
    .scan_last_i (scan_last_i),
    .flags_o     (beam_flags),
    .range_o     (beam_range),
    .sin_idx_o   (sin_idx),
    .cos_idx_o   (cos_idx)
  );

  // table lookup stage
  srop_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i     (clk_i),
    .en_i      (accept),
    .sin_idx_i (sin_idx),
    .cos_idx_i (cos_idx),
    .sin_mag_o (sin_mag),
    .cos_mag_o (cos_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_valid_q <= 1'b0;
    end else if (accept) begin
      lut_valid_q <= beam_flags.kept || beam_flags.last;
    end else if (lut_adv) begin
      lut_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lut_flags_q <= beam_flags;
      lut_range_q <= beam_range;
    end
  end

  // coordinate multiplies
  srop_scale u_scale_x (
    .range_i (lut_range_q),
    .mag_i   (cos_mag),
    .neg_i   (lut_flags_q.cos_neg),
    .kept_i  (lut_flags_q.kept),
    .coord_o (x_d)
  );

  srop_scale u_scale_y (
    .range_i (lut_range_q),
    .mag_i   (sin_mag),
    .neg_i   (lut_flags_q.sin_neg),
    .kept_i  (lut_flags_q.kept),
    .coord_o (y_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lut_adv) begin
      out_valid_q <= lut_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lut_adv && lut_valid_q) begin
      x_q    <= x_d;
      y_q    <= y_d;
      kept_q <= lut_flags_q.kept;
      end_q  <= lut_flags_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = x_q;
  assign point_y_o     = y_q;
  assign point_valid_o = kept_q;
  assign scan_end_o    = end_q;

endmodule
